// File: hdl/pdl_pkg.sv
// ----------------------------------------------------------------------------
// pdl_pkg
// shared types and constants of the door lock controller
// ----------------------------------------------------------------------------
package pdl_pkg;

    localparam int PASSWORD_LEN = 5;
    localparam int IDX_W        = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN) : 1;
    localparam int CFG_IDX_W    = 3;

    localparam logic [7:0] KEY_OPEN   = 8'h2B;
    localparam logic [7:0] KEY_CHANGE = 8'h2D;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic REPLY_MATCH    = 1'b0;
    localparam logic REPLY_MISMATCH = 1'b1;

    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_FWD  = 2'd1;
    localparam logic [1:0] MOTOR_REV  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_SECONDS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SECONDS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SECONDS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_SECONDS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT    = 3'd4;

    localparam logic [7:0] RST_OPEN_SECONDS  = 8'd15;
    localparam logic [7:0] RST_HOLD_SECONDS  = 8'd3;
    localparam logic [7:0] RST_CLOSE_SECONDS = 8'd15;
    localparam logic [7:0] RST_ALARM_SECONDS = 8'd60;
    localparam logic [2:0] RST_FAIL_LIMIT    = 3'd3;

    typedef struct packed {
        logic [7:0] open_seconds;
        logic [7:0] hold_seconds;
        logic [7:0] close_seconds;
        logic [7:0] alarm_seconds;
        logic [2:0] failures_to_alarm;
    } t_cfg;

endpackage

// File: hdl/pdl_ifs.sv
// ----------------------------------------------------------------------------
// pdl interfaces
// request, result and register write channels of the door lock controller
// ----------------------------------------------------------------------------
interface pdl_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] byte_value;

    modport source (output valid, req_type, byte_value, input ready);
    modport sink   (input valid, req_type, byte_value, output ready);
endinterface

interface pdl_out_if;
    logic       valid;
    logic       ready;
    logic       reply_valid;
    logic       reply_code;
    logic [1:0] motor_cmd;
    logic       siren_on;
    logic [3:0] phase_now;

    modport source (output valid, reply_valid, reply_code, motor_cmd, siren_on, phase_now,
                    input ready);
    modport sink   (input valid, reply_valid, reply_code, motor_cmd, siren_on, phase_now,
                    output ready);
endinterface

interface pdl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pdl_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/pdl_cfg_regs.sv
// ----------------------------------------------------------------------------
// pdl_cfg_regs
// timing and failure limit registers, written through the register channel
// ----------------------------------------------------------------------------
module pdl_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pdl_cfg_if.sink         i_cfg,
    output pdl_pkg::t_cfg   o_cfg
);

    pdl_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_seconds      <= pdl_pkg::RST_OPEN_SECONDS;
            r_cfg.hold_seconds      <= pdl_pkg::RST_HOLD_SECONDS;
            r_cfg.close_seconds     <= pdl_pkg::RST_CLOSE_SECONDS;
            r_cfg.alarm_seconds     <= pdl_pkg::RST_ALARM_SECONDS;
            r_cfg.failures_to_alarm <= pdl_pkg::RST_FAIL_LIMIT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pdl_pkg::CFG_OPEN_SECONDS:  r_cfg.open_seconds      <= i_cfg.data;
                pdl_pkg::CFG_HOLD_SECONDS:  r_cfg.hold_seconds      <= i_cfg.data;
                pdl_pkg::CFG_CLOSE_SECONDS: r_cfg.close_seconds     <= i_cfg.data;
                pdl_pkg::CFG_ALARM_SECONDS: r_cfg.alarm_seconds     <= i_cfg.data;
                pdl_pkg::CFG_FAIL_LIMIT:    r_cfg.failures_to_alarm <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/password_door_lock_controller.sv
// ----------------------------------------------------------------------------
// password_door_lock_controller
// password setup, menu, password check, door motor and alarm sequencing
// ----------------------------------------------------------------------------
// Each request word (a keypad byte or a one-second tick) is taken into an
// input register and produces exactly one result word, from a single pass of
// compare and phase logic into the result register. A new
// request is taken every cycle as long as the result register is empty or is
// being drained, so the sustained rate is one word per clock; a stalled
// result holds off at most one further request in the input register.
// Register writes are expected only while no word is in flight.
module password_door_lock_controller (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pdl_in_if.sink    i_in,
    pdl_out_if.source o_out,
    pdl_cfg_if.sink   i_cfg
);

    typedef enum logic [3:0] {
        PH_SETUP1     = 4'd0,
        PH_SETUP2     = 4'd1,
        PH_MENU       = 4'd2,
        PH_CHECK      = 4'd3,
        PH_WAIT_OPEN  = 4'd4,
        PH_OPENING    = 4'd5,
        PH_HOLDING    = 4'd6,
        PH_CLOSING    = 4'd7,
        PH_WAIT_ALARM = 4'd8,
        PH_ALARM      = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        CH_NONE   = 2'd0,
        CH_OPEN   = 2'd1,
        CH_CHANGE = 2'd2
    } t_choice;

    localparam logic [pdl_pkg::IDX_W-1:0] LAST_IDX = pdl_pkg::IDX_W'(pdl_pkg::PASSWORD_LEN - 1);

    pdl_pkg::t_cfg w_cfg;

    pdl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // input register
    logic       r_in_valid;
    logic       r_in_req;
    logic [7:0] r_in_byte;
    logic       w_adv;

    // control state
    t_phase                    r_phase, n_phase;
    logic [pdl_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_mm, n_mm;
    t_choice                   r_choice, n_choice;
    logic [2:0]                r_fail, n_fail;
    logic [7:0]                r_sec, n_sec;

    // password stores
    logic [7:0] r_first [pdl_pkg::PASSWORD_LEN];
    logic [7:0] r_saved [pdl_pkg::PASSWORD_LEN];
    logic       n_first_we;
    logic       n_save;

    // result register
    logic       r_out_valid;
    logic       r_reply_valid, n_reply_valid;
    logic       r_reply_code, n_reply_code;
    logic [1:0] r_motor, n_motor;
    logic       r_buzzer, n_buzzer;

    logic       w_last;
    logic [7:0] w_sec_inc;
    logic [7:0] w_limit;
    logic       w_time_up;
    logic       w_mm_first;
    logic       w_mm_saved;
    logic       w_fail_hit;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_req  <= i_in.req_type;
            r_in_byte <= i_in.byte_value;
        end
    end

    assign w_last     = (r_idx == LAST_IDX);
    assign w_sec_inc  = r_sec + 8'd1;
    assign w_time_up  = (w_sec_inc >= w_limit) || (w_sec_inc == 8'd0);
    assign w_mm_first = r_mm || (r_first[r_idx] != r_in_byte);
    assign w_mm_saved = r_mm || (r_saved[r_idx] != r_in_byte);
    assign w_fail_hit = ({1'b0, r_fail} + 4'd1) >= {1'b0, w_cfg.failures_to_alarm};

    always_comb begin
        unique case (r_phase)
            PH_OPENING: w_limit = w_cfg.open_seconds;
            PH_HOLDING: w_limit = w_cfg.hold_seconds;
            PH_CLOSING: w_limit = w_cfg.close_seconds;
            default:    w_limit = w_cfg.alarm_seconds;
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_idx         = r_idx;
        n_mm          = r_mm;
        n_choice      = r_choice;
        n_fail        = r_fail;
        n_sec         = r_sec;
        n_first_we    = 1'b0;
        n_save        = 1'b0;
        n_reply_valid = 1'b0;
        n_reply_code  = pdl_pkg::REPLY_MATCH;

        if (r_in_req == pdl_pkg::REQ_TICK) begin
            unique case (r_phase)
                PH_OPENING, PH_HOLDING, PH_CLOSING, PH_ALARM: begin
                    n_sec = w_sec_inc;
                    if (w_time_up) begin
                        n_sec = 8'd0;
                        unique case (r_phase)
                            PH_OPENING: n_phase = PH_HOLDING;
                            PH_HOLDING: n_phase = PH_CLOSING;
                            default: begin
                                n_phase  = PH_MENU;
                                n_idx    = '0;
                                n_mm     = 1'b0;
                                n_choice = CH_NONE;
                            end
                        endcase
                    end
                end
                PH_SETUP1, PH_SETUP2, PH_MENU, PH_CHECK, PH_WAIT_OPEN, PH_WAIT_ALARM: ;
                default: begin
                    n_phase  = PH_SETUP1;
                    n_idx    = '0;
                    n_mm     = 1'b0;
                    n_choice = CH_NONE;
                end
            endcase
        end else begin
            unique case (r_phase)
                PH_SETUP1: begin
                    n_first_we = 1'b1;
                    if (w_last) begin
                        n_phase = PH_SETUP2;
                        n_idx   = '0;
                        n_mm    = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                PH_SETUP2: begin
                    n_mm = w_mm_first;
                    if (w_last) begin
                        n_reply_valid = 1'b1;
                        n_idx         = '0;
                        n_mm          = 1'b0;
                        n_choice      = CH_NONE;
                        if (w_mm_first) begin
                            n_reply_code = pdl_pkg::REPLY_MISMATCH;
                            n_phase      = PH_SETUP1;
                        end else begin
                            n_save  = 1'b1;
                            n_phase = PH_MENU;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                PH_MENU: begin
                    if (r_in_byte == pdl_pkg::KEY_OPEN || r_in_byte == pdl_pkg::KEY_CHANGE) begin
                        n_choice = (r_in_byte == pdl_pkg::KEY_OPEN) ? CH_OPEN : CH_CHANGE;
                        n_fail   = 3'd0;
                        n_phase  = PH_CHECK;
                        n_idx    = '0;
                        n_mm     = 1'b0;
                    end
                end
                PH_CHECK: begin
                    n_mm = w_mm_saved;
                    if (w_last) begin
                        n_reply_valid = 1'b1;
                        n_idx         = '0;
                        if (!w_mm_saved) begin
                            if (r_choice == CH_OPEN) begin
                                n_phase = PH_WAIT_OPEN;
                            end else begin
                                n_phase  = PH_SETUP1;
                                n_mm     = 1'b0;
                                n_choice = CH_NONE;
                            end
                        end else begin
                            n_reply_code = pdl_pkg::REPLY_MISMATCH;
                            n_mm         = 1'b0;
                            if (w_fail_hit) begin
                                n_phase = PH_WAIT_ALARM;
                            end else begin
                                n_fail = r_fail + 3'd1;
                            end
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                PH_WAIT_OPEN: begin
                    n_phase = PH_OPENING;
                    n_sec   = 8'd0;
                end
                PH_WAIT_ALARM: begin
                    n_phase = PH_ALARM;
                    n_sec   = 8'd0;
                end
                PH_OPENING, PH_HOLDING, PH_CLOSING, PH_ALARM: ;
                default: begin
                    n_phase  = PH_SETUP1;
                    n_idx    = '0;
                    n_mm     = 1'b0;
                    n_choice = CH_NONE;
                end
            endcase
        end

        n_motor  = (n_phase == PH_OPENING) ? pdl_pkg::MOTOR_FWD :
                   (n_phase == PH_CLOSING) ? pdl_pkg::MOTOR_REV : pdl_pkg::MOTOR_STOP;
        n_buzzer = (n_phase == PH_ALARM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SETUP1;
            r_idx       <= '0;
            r_mm        <= 1'b0;
            r_choice    <= CH_NONE;
            r_fail      <= 3'd0;
            r_sec       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase       <= n_phase;
                r_idx         <= n_idx;
                r_mm          <= n_mm;
                r_choice      <= n_choice;
                r_fail        <= n_fail;
                r_sec         <= n_sec;
                r_reply_valid <= n_reply_valid;
                r_reply_code  <= n_reply_code;
                r_motor       <= n_motor;
                r_buzzer      <= n_buzzer;
                if (n_first_we) begin
                    r_first[r_idx] <= r_in_byte;
                end
                if (n_save) begin
                    r_saved <= r_first;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.reply_valid = r_reply_valid;
    assign o_out.reply_code  = r_reply_code;
    assign o_out.motor_cmd   = r_motor;
    assign o_out.siren_on    = r_buzzer;
    assign o_out.phase_now   = r_phase;

    // a full input register with a stalled result must hold off new words
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("request taken while result stalled");

    // a mismatch code only comes with a reply
    a_code_needs_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_reply_code) |-> r_reply_valid)
        else $error("mismatch code without reply");

    // the alarm wait is only reached from a password check
    a_alarm_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT_ALARM && $past(r_phase) != PH_WAIT_ALARM)
            |-> $past(r_phase) == PH_CHECK)
        else $error("alarm wait entered from wrong phase");

    // leaving the alarm always lands in the menu
    a_alarm_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_phase) == PH_ALARM && r_phase != PH_ALARM) |-> r_phase == PH_MENU)
        else $error("alarm left to wrong phase");

    // digit index stays inside the password
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("digit index out of range");

endmodule
